>>> design/nps_pkg.sv
// Shared codes and types of the nine-point stencil residual block.
package nps_pkg;

    // Width of every data field on the channels.
    localparam int FIELD_W = 32;

    // Number of coefficients loaded per grid row.
    localparam int NUM_COEF = 6;

    // Item kinds carried in the mode field.
    localparam logic [1:0] MODE_COEF   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;

    // Per-item control that rides along the arithmetic pipeline.
    typedef struct packed {
        logic               rvalid;
        logic               evalid;
        logic               done;
        logic [FIELD_W-1:0] err_re;
        logic [FIELD_W-1:0] err_im;
    } t_ctl;

endpackage

>>> design/nps_chan_if.sv
// Channel interfaces: input words, result words and configuration writes.
interface nps_in_if;
    import nps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                mode;
    logic [9:0]                coef_row;
    logic [2:0]                coef_select;
    logic signed [FIELD_W-1:0] coef_re;
    logic signed [FIELD_W-1:0] coef_im;
    logic signed [FIELD_W-1:0] sol_re;
    logic signed [FIELD_W-1:0] sol_im;
    logic signed [FIELD_W-1:0] rhs_re;
    logic signed [FIELD_W-1:0] rhs_im;
    logic signed [FIELD_W-1:0] exact_re;
    logic signed [FIELD_W-1:0] exact_im;

    modport source (output valid, mode, coef_row, coef_select, coef_re, coef_im,
                    sol_re, sol_im, rhs_re, rhs_im, exact_re, exact_im,
                    input ready);
    modport sink (input valid, mode, coef_row, coef_select, coef_re, coef_im,
                  sol_re, sol_im, rhs_re, rhs_im, exact_re, exact_im,
                  output ready);
endinterface

interface nps_out_if;
    import nps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] residual_re;
    logic signed [FIELD_W-1:0] residual_im;
    logic                      residual_valid;
    logic signed [FIELD_W-1:0] error_re;
    logic signed [FIELD_W-1:0] error_im;
    logic                      error_valid;
    logic                      frame_done;

    modport source (output valid, residual_re, residual_im, residual_valid,
                    error_re, error_im, error_valid, frame_done, input ready);
    modport sink (input valid, residual_re, residual_im, residual_valid,
                  error_re, error_im, error_valid, frame_done, output ready);
endinterface

interface nps_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/nps_ram.sv
// Simple dual-port synchronous RAM with a registered, enabled read.
module nps_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int W     = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [0:DEPTH-1];
    logic [W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/nps_datapath.sv
// Stencil arithmetic: complex products, rounding, adder tree and saturation.
module nps_datapath import nps_pkg::*; #(
    parameter int DATA_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  t_ctl                     i_ctl,
    input  logic signed [DATA_W-1:0] i_win_re [0:8],
    input  logic signed [DATA_W-1:0] i_win_im [0:8],
    input  logic signed [DATA_W-1:0] i_coef_re [0:8],
    input  logic signed [DATA_W-1:0] i_coef_im [0:8],
    input  logic signed [DATA_W-1:0] i_old_re,
    input  logic signed [DATA_W-1:0] i_old_im,
    output logic                     o_valid,
    output logic [FIELD_W-1:0]       o_res_re,
    output logic [FIELD_W-1:0]       o_res_im,
    output t_ctl                     o_ctl
);

    localparam int PW = 2 * DATA_W;
    localparam int SW = 2 * DATA_W + 6;
    localparam logic signed [SW-1:0] RND    = SW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic                 r_s2_v, r_s3_v, r_s4_v, r_o_v;
    t_ctl                 r_s2_ctl, r_s3_ctl, r_s4_ctl, r_o_ctl;
    logic signed [PW-1:0] r_p [0:8][0:3];
    logic signed [DATA_W-1:0] r_s2_old_re, r_s2_old_im;
    logic signed [SW-1:0] r_s3_old_re, r_s3_old_im;
    logic signed [SW-1:0] r_t_re [0:8];
    logic signed [SW-1:0] r_t_im [0:8];
    logic signed [SW-1:0] r_g_re [0:3];
    logic signed [SW-1:0] r_g_im [0:3];
    logic [FIELD_W-1:0]   r_res_re, r_res_im;
    logic signed [SW-1:0] w_rp [0:8][0:3];
    logic signed [SW-1:0] w_sum_re, w_sum_im;
    logic signed [DATA_W-1:0] w_sat_re, w_sat_im;

    // Valid bits of the arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (i_adv) begin
            r_s2_v <= i_valid;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_o_v  <= r_s4_v && (r_s4_ctl.rvalid || r_s4_ctl.evalid);
        end
    end

    // Four real products per tap.
    for (genvar t = 0; t < 9; t++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_p[t][0] <= PW'(i_coef_re[t]) * PW'(i_win_re[t]);
                r_p[t][1] <= PW'(i_coef_im[t]) * PW'(i_win_im[t]);
                r_p[t][2] <= PW'(i_coef_re[t]) * PW'(i_win_im[t]);
                r_p[t][3] <= PW'(i_coef_im[t]) * PW'(i_win_re[t]);
            end
        end

        // Round each product to the fraction width, then form the complex tap.
        for (genvar k = 0; k < 4; k++) begin : g_rnd
            assign w_rp[t][k] = (SW'(r_p[t][k]) + RND) >>> FRAC_BITS;
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_t_re[t] <= w_rp[t][0] - w_rp[t][1];
                r_t_im[t] <= w_rp[t][2] + w_rp[t][3];
            end
        end
    end

    // Control and right-hand side delay alongside the products.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_ctl    <= i_ctl;
            r_s2_old_re <= i_old_re;
            r_s2_old_im <= i_old_im;
            r_s3_ctl    <= r_s2_ctl;
            r_s3_old_re <= -SW'(r_s2_old_re);
            r_s3_old_im <= -SW'(r_s2_old_im);
            r_s4_ctl    <= r_s3_ctl;
        end
    end

    // Sum the taps of each window row; the negated right-hand side is a fourth group.
    for (genvar g = 0; g < 3; g++) begin : g_row
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_g_re[g] <= r_t_re[3*g] + r_t_re[3*g+1] + r_t_re[3*g+2];
                r_g_im[g] <= r_t_im[3*g] + r_t_im[3*g+1] + r_t_im[3*g+2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_g_re[3] <= r_s3_old_re;
            r_g_im[3] <= r_s3_old_im;
        end
    end

    // Final sum and saturation to the data range.
    always_comb begin
        w_sum_re = r_g_re[0] + r_g_re[1] + r_g_re[2] + r_g_re[3];
        w_sum_im = r_g_im[0] + r_g_im[1] + r_g_im[2] + r_g_im[3];
        if (w_sum_re > SAT_HI) begin
            w_sat_re = DATA_W'(SAT_HI);
        end else if (w_sum_re < SAT_LO) begin
            w_sat_re = DATA_W'(SAT_LO);
        end else begin
            w_sat_re = DATA_W'(w_sum_re);
        end
        if (w_sum_im > SAT_HI) begin
            w_sat_im = DATA_W'(SAT_HI);
        end else if (w_sum_im < SAT_LO) begin
            w_sat_im = DATA_W'(SAT_LO);
        end else begin
            w_sat_im = DATA_W'(w_sum_im);
        end
    end

    // Output register; residual fields read zero when no residual is given.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_o_ctl  <= r_s4_ctl;
            r_res_re <= r_s4_ctl.rvalid ? FIELD_W'(w_sat_re) : '0;
            r_res_im <= r_s4_ctl.rvalid ? FIELD_W'(w_sat_im) : '0;
        end
    end

    assign o_valid  = r_o_v;
    assign o_ctl    = r_o_ctl;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;

endmodule

>>> design/nine_point_stencil_residual.sv
// Top level of the nine-point complex stencil residual block.
//
// Words arrive on i_in: coefficient loads (mode 0), grid samples in raster order
// (mode 1) and flush words (mode 2). Coefficients of a row are loaded before
// the samples that need them. i_cfg writes column_count (index 0) and row_count
// (index 1); the user writes them only while the block is idle, which the block
// does not enforce. A write restarts the frame. o_out carries one word per
// sample: its error at once, together with the residual of the point one row
// plus one sample earlier. Flush words after the last sample of a frame push
// out the remaining residuals; frame_done marks the last one.
// A word is taken every cycle while o_out does not stall. After its word is
// accepted, a result passes the line and coefficient memory reads, then the
// products, rounding with the tap sums, the row sums, and the final sum into
// the output register.
// When o_out stalls the whole pipe holds and i_in.ready drops with it, so no
// word is lost. Reset clears the counters and restores both registers to the
// full grid; the memories are not cleared and rows are read only after written.
module nine_point_stencil_residual import nps_pkg::*; #(
    parameter int MAX_COLS  = 1024,
    parameter int MAX_ROWS  = 1024,
    parameter int DATA_W    = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nps_in_if.sink   i_in,
    nps_out_if.source o_out,
    nps_cfg_if.sink  i_cfg
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS + 3);
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int RA_W   = $clog2(MAX_COLS + 1);
    localparam int TOT_W  = CW + RW + 1;
    localparam int NX_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int NY_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
    localparam int CPX_W  = 2 * DATA_W;

    // Frame counters and registers.
    logic [CW-1:0]    r_nx, n_nx;
    logic [RW-1:0]    r_ny, n_ny;
    logic [TOT_W-1:0] r_total, r_shift, r_emit;
    logic [COL_W-1:0] r_col, r_la;
    logic [ROW_W-1:0] r_row;
    logic [RA_W-1:0]  r_ra;
    logic [CW-1:0]    r_pend, w_pend_inc;

    // Stage one registers.
    logic                     r_s1_v;
    logic [COL_W-1:0]         r_s1_la;
    logic [RA_W-1:0]          r_s1_ra;
    t_ctl                     r_s1_ctl;
    logic signed [DATA_W-1:0] r_s1_smp_re, r_s1_smp_im, r_s1_rhs_re, r_s1_rhs_im;
    logic [8:0]               r_s1_mask;
    logic                     r_fwd;
    logic [CPX_W-1:0]         r_fwd_prev, r_fwd_mid;
    logic signed [DATA_W-1:0] r_win_re [0:8];
    logic signed [DATA_W-1:0] r_win_im [0:8];

    logic                     w_adv, w_acc, w_go, w_fire, w_last, w_cfg_wr;
    logic                     w_take_smp, w_take_fl, w_is_smp;
    logic [8:0]               w_mask;
    logic [2:0]               w_rowok, w_colok;
    t_ctl                     w_ctl;
    logic [CPX_W-1:0]         w_q_prev, w_q_older, w_q_rhs, w_prev_d, w_older_d;
    logic [CPX_W-1:0]         w_coef_q [0:NUM_COEF-1];
    logic signed [DATA_W-1:0] n_win_re [0:8];
    logic signed [DATA_W-1:0] n_win_im [0:8];
    logic signed [DATA_W-1:0] w_win_re [0:8];
    logic signed [DATA_W-1:0] w_win_im [0:8];
    logic signed [DATA_W-1:0] w_coef_re [0:8];
    logic signed [DATA_W-1:0] w_coef_im [0:8];
    logic signed [DATA_W:0]   w_err_re, w_err_im;
    logic signed [DATA_W-1:0] w_esat_re, w_esat_im;
    logic                     w_row_ok;
    logic                     w_dp_valid;
    t_ctl                     w_dp_ctl;
    logic [FIELD_W-1:0]       w_res_re, w_res_im;

    assign w_adv    = !w_dp_valid || o_out.ready;
    assign w_acc    = i_in.valid && w_adv;
    assign w_cfg_wr = i_cfg.valid && i_cfg.ready;
    assign w_is_smp = (i_in.mode == MODE_SAMPLE);

    // Decide whether a sample or flush word moves the window.
    always_comb begin
        w_take_smp = w_is_smp && (r_shift < r_total);
        w_take_fl  = (i_in.mode == MODE_FLUSH) && (r_shift >= r_total) && (r_emit < r_total);
        w_go       = w_acc && (w_take_smp || w_take_fl);
        w_pend_inc = r_pend + CW'(1);
        w_fire     = (w_pend_inc >= r_nx + CW'(2));
        w_last     = (r_emit + TOT_W'(1) >= r_total);
    end

    // Clamp configuration values into the supported range.
    always_comb begin
        if (i_cfg.data == '0) begin
            n_nx = CW'(1);
            n_ny = RW'(1);
        end else begin
            n_nx = (32'(i_cfg.data) > MAX_COLS) ? CW'(MAX_COLS) : CW'(i_cfg.data);
            n_ny = (32'(i_cfg.data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(i_cfg.data);
        end
    end

    // Grid size product; a register write takes the new value at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOT_W'(NX_RST * NY_RST);
        end else if (w_cfg_wr && i_cfg.index == CFG_COLUMN_COUNT) begin
            r_total <= TOT_W'(n_nx) * TOT_W'(r_ny);
        end else if (w_cfg_wr && i_cfg.index == CFG_ROW_COUNT) begin
            r_total <= TOT_W'(r_nx) * TOT_W'(n_ny);
        end else begin
            r_total <= TOT_W'(r_nx) * TOT_W'(r_ny);
        end
    end

    // Frame position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx    <= CW'(NX_RST);
            r_ny    <= RW'(NY_RST);
            r_shift <= '0;
            r_emit  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_la    <= '0;
            r_ra    <= '0;
            r_pend  <= '0;
        end else if (w_cfg_wr && (i_cfg.index == CFG_COLUMN_COUNT ||
                                  i_cfg.index == CFG_ROW_COUNT)) begin
            if (i_cfg.index == CFG_COLUMN_COUNT) begin
                r_nx <= n_nx;
            end else begin
                r_ny <= n_ny;
            end
            r_shift <= '0;
            r_emit  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_la    <= '0;
            r_ra    <= '0;
            r_pend  <= '0;
        end else if (w_go) begin
            r_shift <= r_shift + TOT_W'(1);
            r_la    <= (CW'(r_la) + CW'(1) == r_nx) ? '0 : r_la + COL_W'(1);
            r_ra    <= (CW'(r_ra) == r_nx) ? '0 : r_ra + RA_W'(1);
            if (w_fire) begin
                r_pend <= r_nx + CW'(1);
                r_emit <= r_emit + TOT_W'(1);
                if (w_last) begin
                    r_shift <= '0;
                    r_emit  <= '0;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_la    <= '0;
                    r_ra    <= '0;
                    r_pend  <= '0;
                end else if (CW'(r_col) + CW'(1) == r_nx) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end else begin
                r_pend <= w_pend_inc;
            end
        end
    end

    // Edge masks and the error of the incoming sample.
    always_comb begin
        w_rowok[0] = (RW'(r_row) + RW'(1) < r_ny);
        w_rowok[1] = 1'b1;
        w_rowok[2] = (r_row != '0);
        w_colok[0] = (CW'(r_col) + CW'(1) < r_nx);
        w_colok[1] = 1'b1;
        w_colok[2] = (r_col != '0);
        for (int t = 0; t < 9; t++) begin
            w_mask[t] = w_rowok[t / 3] && w_colok[t % 3];
        end
        w_err_re = (DATA_W+1)'($signed(i_in.sol_re[DATA_W-1:0]))
                 - (DATA_W+1)'($signed(i_in.exact_re[DATA_W-1:0]));
        w_err_im = (DATA_W+1)'($signed(i_in.sol_im[DATA_W-1:0]))
                 - (DATA_W+1)'($signed(i_in.exact_im[DATA_W-1:0]));
        if (w_err_re[DATA_W] != w_err_re[DATA_W-1]) begin
            w_esat_re = w_err_re[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_esat_re = w_err_re[DATA_W-1:0];
        end
        if (w_err_im[DATA_W] != w_err_im[DATA_W-1]) begin
            w_esat_im = w_err_im[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_esat_im = w_err_im[DATA_W-1:0];
        end
        w_ctl.rvalid = w_fire;
        w_ctl.evalid = w_take_smp;
        w_ctl.done   = w_fire && w_last;
        w_ctl.err_re = w_take_smp ? FIELD_W'(w_esat_re) : '0;
        w_ctl.err_im = w_take_smp ? FIELD_W'(w_esat_im) : '0;
    end

    // Stage one: capture the word while the memories are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_go;
            r_fwd  <= r_s1_v && (r_s1_la == r_la);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_la     <= r_la;
            r_s1_ra     <= r_ra;
            r_s1_ctl    <= w_ctl;
            r_s1_mask   <= w_mask;
            r_s1_smp_re <= w_is_smp ? $signed(i_in.sol_re[DATA_W-1:0]) : '0;
            r_s1_smp_im <= w_is_smp ? $signed(i_in.sol_im[DATA_W-1:0]) : '0;
            r_s1_rhs_re <= w_is_smp ? $signed(i_in.rhs_re[DATA_W-1:0]) : '0;
            r_s1_rhs_im <= w_is_smp ? $signed(i_in.rhs_im[DATA_W-1:0]) : '0;
            r_fwd_prev  <= {r_s1_smp_re, r_s1_smp_im};
            r_fwd_mid   <= w_prev_d;
        end
    end

    // Line and right-hand side memories.
    nps_ram #(.DEPTH(MAX_COLS), .AW(COL_W), .W(CPX_W)) u_prev_line (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_s1_v),
        .i_waddr (r_s1_la),
        .i_wdata ({r_s1_smp_re, r_s1_smp_im}),
        .i_re    (w_adv),
        .i_raddr (r_la),
        .o_rdata (w_q_prev)
    );

    nps_ram #(.DEPTH(MAX_COLS), .AW(COL_W), .W(CPX_W)) u_older_line (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_s1_v),
        .i_waddr (r_s1_la),
        .i_wdata (w_prev_d),
        .i_re    (w_adv),
        .i_raddr (r_la),
        .o_rdata (w_q_older)
    );

    nps_ram #(.DEPTH(MAX_COLS + 1), .AW(RA_W), .W(CPX_W)) u_rhs_line (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_s1_v),
        .i_waddr (r_s1_ra),
        .i_wdata ({r_s1_rhs_re, r_s1_rhs_im}),
        .i_re    (w_adv),
        .i_raddr (r_ra),
        .o_rdata (w_q_rhs)
    );

    // One coefficient memory per select, addressed by grid row.
    assign w_row_ok = (32'(i_in.coef_row) < MAX_ROWS);

    for (genvar k = 0; k < NUM_COEF; k++) begin : g_coef
        nps_ram #(.DEPTH(MAX_ROWS), .AW(ROW_W), .W(CPX_W)) u_coef (
            .i_clk   (i_clk),
            .i_we    (w_acc && i_in.mode == MODE_COEF && w_row_ok &&
                      i_in.coef_select == 3'(k)),
            .i_waddr (ROW_W'(i_in.coef_row)),
            .i_wdata ({i_in.coef_re[DATA_W-1:0], i_in.coef_im[DATA_W-1:0]}),
            .i_re    (w_adv),
            .i_raddr (r_row),
            .o_rdata (w_coef_q[k])
        );
    end

    // Line data with forwarding when the previous word wrote the same column.
    assign w_prev_d  = r_fwd ? r_fwd_prev : w_q_prev;
    assign w_older_d = r_fwd ? r_fwd_mid  : w_q_older;

    // Next window: shift each row left and insert the new column.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win_re[3*r+2] = r_win_re[3*r+1];
            n_win_im[3*r+2] = r_win_im[3*r+1];
            n_win_re[3*r+1] = r_win_re[3*r];
            n_win_im[3*r+1] = r_win_im[3*r];
        end
        n_win_re[0] = r_s1_smp_re;
        n_win_im[0] = r_s1_smp_im;
        n_win_re[3] = w_prev_d[CPX_W-1:DATA_W];
        n_win_im[3] = w_prev_d[DATA_W-1:0];
        n_win_re[6] = w_older_d[CPX_W-1:DATA_W];
        n_win_im[6] = w_older_d[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 9; t++) begin
                r_win_re[t] <= '0;
                r_win_im[t] <= '0;
            end
        end else if (w_adv && r_s1_v) begin
            r_win_re <= n_win_re;
            r_win_im <= n_win_im;
        end
    end

    // Coefficient and sample of each tap; taps off the grid get zero.
    for (genvar t = 0; t < 9; t++) begin : g_tap
        localparam int SEL = (t / 3) * 2 + ((t % 3 == 1) ? 0 : 1);
        assign w_coef_re[t] = r_s1_mask[t] ? w_coef_q[SEL][CPX_W-1:DATA_W] : '0;
        assign w_coef_im[t] = r_s1_mask[t] ? w_coef_q[SEL][DATA_W-1:0] : '0;
        assign w_win_re[t]  = r_s1_mask[t] ? n_win_re[t] : '0;
        assign w_win_im[t]  = r_s1_mask[t] ? n_win_im[t] : '0;
    end

    nps_datapath #(.DATA_W(DATA_W), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (r_s1_v),
        .i_ctl     (r_s1_ctl),
        .i_win_re  (w_win_re),
        .i_win_im  (w_win_im),
        .i_coef_re (w_coef_re),
        .i_coef_im (w_coef_im),
        .i_old_re  (w_q_rhs[CPX_W-1:DATA_W]),
        .i_old_im  (w_q_rhs[DATA_W-1:0]),
        .o_valid   (w_dp_valid),
        .o_res_re  (w_res_re),
        .o_res_im  (w_res_im),
        .o_ctl     (w_dp_ctl)
    );

    // Channel outputs.
    assign i_in.ready           = w_adv;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = w_dp_valid;
    assign o_out.residual_re    = w_res_re;
    assign o_out.residual_im    = w_res_im;
    assign o_out.residual_valid = w_dp_ctl.rvalid;
    assign o_out.error_re       = w_dp_ctl.err_re;
    assign o_out.error_im       = w_dp_ctl.err_im;
    assign o_out.error_valid    = w_dp_ctl.evalid;
    assign o_out.frame_done     = w_dp_ctl.done;

endmodule
